[hdl/siq_pkg.sv]
package siq_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned LENGTH_W   = 5;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_SORT_DESCENDING = 3'd0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 2'd0,
      FUNC_PUSH_REAR  = 2'd1,
      FUNC_SORTED     = 2'd2,
      FUNC_POP_FRONT  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MODE_HOLD   = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_POP    = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      func_type                  func;
      logic signed [DATA_W-1:0]  value;
      logic                      descending;
   } cell_ctrl_type;

endpackage

[hdl/siq_if.sv]
interface siq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [siq_pkg::FUNC_W-1:0]            func;
   logic signed [siq_pkg::DATA_W-1:0]     value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface siq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [siq_pkg::DATA_W-1:0]     popped_value;
   logic                                  pop_valid;
   logic [siq_pkg::STATUS_W-1:0]          status;
   logic [siq_pkg::LENGTH_W-1:0]          length;
   logic                                  is_empty;

   modport source (output valid, output popped_value, output pop_valid, output status,
                   output length, output is_empty, input ready);
   modport sink   (input valid, input popped_value, input pop_valid, input status,
                   input length, input is_empty, output ready);
endinterface

[hdl/siq_cell.sv]
module siq_cell (
   input  logic                                  clock,
   input  siq_pkg::cell_ctrl_type                ctrl,
   input  logic                                  is_head,
   input  logic                                  occupied,
   input  logic                                  at_tail,
   input  logic signed [siq_pkg::DATA_W-1:0]     left_value,
   input  logic signed [siq_pkg::DATA_W-1:0]     right_value,
   input  logic                                  before_in,
   output logic                                  before_out,
   output logic signed [siq_pkg::DATA_W-1:0]     value_ff
);

   logic signed [siq_pkg::DATA_W-1:0] value_in;
   logic                              goes_before;
   logic                              hit;

   assign goes_before = ctrl.descending ? (value_ff < ctrl.value) : (value_ff > ctrl.value);

   always_comb begin
      case (ctrl.func)
         siq_pkg::FUNC_PUSH_FRONT: hit = is_head;
         siq_pkg::FUNC_PUSH_REAR:  hit = at_tail;
         siq_pkg::FUNC_SORTED:     hit = at_tail | (occupied & goes_before);
         default:                  hit = 1'b0;
      endcase
   end

   assign before_out = before_in | hit;

   always_comb begin
      case (ctrl.mode)
         siq_pkg::MODE_INSERT: begin
            if (before_in) begin
               value_in = left_value;
            end else if (hit) begin
               value_in = ctrl.value;
            end else begin
               value_in = value_ff;
            end
         end
         siq_pkg::MODE_POP: value_in = right_value;
         default:           value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[hdl/sorted_insert_queue_top.sv]
// Bounded queue of signed 32-bit values kept as a row of DEPTH cells, front in cell 0.
// Every operation (push front, push rear, sorted insert, pop front) acts on the whole row:
// all cells compare against the new value at once and the insert position ripples from head
// to tail through the cell chain, so one beat is taken per clock while the request port is
// ready, and its response beat is registered and shows up the cycle after. A new request is
// taken while the response register is empty or being drained. Sorted insert goes after
// equal entries; its order follows the sort_descending register, csr byte address 0.
module sorted_insert_queue_top #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   siq_req_if.sink                               req_bus,
   siq_rsp_if.source                             rsp_bus,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [siq_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [siq_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [siq_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic                                  descending_ff;
   logic [CW-1:0]                         count_ff;
   logic [CW-1:0]                         count_in;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic signed [siq_pkg::DATA_W-1:0]     popped_ff;
   logic signed [siq_pkg::DATA_W-1:0]     popped_in;
   logic                                  pop_valid_ff;
   logic                                  pop_valid_in;
   siq_pkg::status_type                   status_ff;
   siq_pkg::status_type                   status_in;
   logic [siq_pkg::LENGTH_W-1:0]          length_ff;
   logic                                  empty_ff;

   logic                                  accept;
   logic                                  full;
   logic                                  empty;
   siq_pkg::func_type                     func;
   siq_pkg::cell_ctrl_type                ctrl;
   logic signed [siq_pkg::DATA_W-1:0]     cell_value [DEPTH];
   logic                                  shift_chain [DEPTH+1];
   logic                                  csr_write;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == siq_pkg::CSR_SORT_DESCENDING[2])
                       ? {{(siq_pkg::CSR_DATA_W-1){1'b0}}, descending_ff}
                       : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff <= 1'b0;
      end else if (csr_write && csr_paddr[2] == siq_pkg::CSR_SORT_DESCENDING[2]) begin
         descending_ff <= csr_pwdata[0];
      end
   end

   // request decode
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign func          = siq_pkg::func_type'(req_bus.func);
   assign full          = count_ff == CW'(DEPTH);
   assign empty         = count_ff == '0;

   always_comb begin
      ctrl.mode       = siq_pkg::MODE_HOLD;
      ctrl.func       = func;
      ctrl.value      = req_bus.value;
      ctrl.descending = descending_ff;
      count_in        = count_ff;
      popped_in       = '0;
      pop_valid_in    = 1'b0;
      status_in       = siq_pkg::STATUS_OK;
      if (func == siq_pkg::FUNC_POP_FRONT) begin
         if (empty) begin
            status_in = siq_pkg::STATUS_EMPTY;
         end else begin
            ctrl.mode    = accept ? siq_pkg::MODE_POP : siq_pkg::MODE_HOLD;
            popped_in    = cell_value[0];
            pop_valid_in = 1'b1;
            count_in     = CW'(count_ff - 1'b1);
         end
      end else if (full) begin
         status_in = siq_pkg::STATUS_FULL;
      end else begin
         ctrl.mode = accept ? siq_pkg::MODE_INSERT : siq_pkg::MODE_HOLD;
         count_in  = CW'(count_ff + 1'b1);
      end
   end

   // cell chain
   assign shift_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      siq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .is_head     (i == 0),
         .occupied    (CW'(i) < count_ff),
         .at_tail     (CW'(i) == count_ff),
         .left_value  ((i == 0) ? req_bus.value : cell_value[(i == 0) ? 0 : i-1]),
         .right_value (cell_value[(i == DEPTH-1) ? i : i+1]),
         .before_in   (shift_chain[i]),
         .before_out  (shift_chain[i+1]),
         .value_ff    (cell_value[i])
      );
   end

   // occupancy and response register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff    <= popped_in;
         pop_valid_ff <= pop_valid_in;
         status_ff    <= status_in;
         length_ff    <= siq_pkg::LENGTH_W'(count_in);
         empty_ff     <= count_in == '0;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.popped_value = popped_ff;
   assign rsp_bus.pop_valid    = pop_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.length       = length_ff;
   assign rsp_bus.is_empty     = empty_ff;

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   assert property (@(posedge clock) disable iff (reset) accept |=> rsp_valid_ff)
      else $error("accepted beat produced no response");

   assert property (@(posedge clock) disable iff (reset)
      accept && func == siq_pkg::FUNC_POP_FRONT && !empty
      |=> count_ff == CW'($past(count_ff) - 1'b1) && pop_valid_ff)
      else $error("pop did not remove the front entry");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && pop_valid_ff |-> status_ff == siq_pkg::STATUS_OK)
      else $error("popped value reported with error status");

endmodule

[tb/sv/sorted_insert_queue_top_test.sv]
`timescale 1ns / 1ps

module sorted_insert_queue_top_test;

   localparam int unsigned QUEUE_DEPTH      = 16;
   localparam int unsigned PHASES           = 5;
   localparam int unsigned RANDOM_PER_PHASE = 256;
   localparam int unsigned HOLD_CYCLES      = 300;
   localparam int unsigned STALL_LIMIT      = 5000;

   typedef struct packed {
      logic signed [siq_pkg::DATA_W-1:0] popped_value;
      logic                              pop_valid;
      siq_pkg::status_type               status;
      logic [siq_pkg::LENGTH_W-1:0]      length;
      logic                              is_empty;
   } rsp_beat_type;

   typedef struct {
      bit           fixed;
      rsp_beat_type want;
   } table_rsp_type;

   typedef struct {
      siq_pkg::func_type                 func;
      logic signed [siq_pkg::DATA_W-1:0] value;
      bit                                fixed;
      rsp_beat_type                      want;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [siq_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [siq_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [siq_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   siq_req_if req_if ();
   siq_rsp_if rsp_if ();

   sorted_insert_queue_top #(.DEPTH(QUEUE_DEPTH)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic signed [siq_pkg::DATA_W-1:0] held_values[$];
   logic                              descending_order = 1'b0;
   rsp_beat_type                      pending_rsp[$];
   table_rsp_type                     table_rsp[$];

   bit          steady       = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned fail_count   = 0;
   int unsigned stall_cycles = 0;
   int unsigned beats_in     = 0;
   int unsigned pops_done    = 0;
   int unsigned full_drops   = 0;
   int unsigned empty_pops   = 0;

   rsp_beat_type  got_beat;
   rsp_beat_type  want_beat;
   table_rsp_type row_info;

   stim_row_type directed_rows [24] = '{
      '{siq_pkg::FUNC_POP_FRONT,  32'sd0,        1'b1,
        '{32'sd0, 1'b0, siq_pkg::STATUS_EMPTY, 5'd0, 1'b1}},
      '{siq_pkg::FUNC_PUSH_FRONT, 32'sh7fffffff, 1'b1,
        '{32'sd0, 1'b0, siq_pkg::STATUS_OK, 5'd1, 1'b0}},
      '{siq_pkg::FUNC_POP_FRONT,  32'sd0,        1'b1,
        '{32'sh7fffffff, 1'b1, siq_pkg::STATUS_OK, 5'd0, 1'b1}},
      '{siq_pkg::FUNC_PUSH_REAR,  32'sh80000000, 1'b1,
        '{32'sd0, 1'b0, siq_pkg::STATUS_OK, 5'd1, 1'b0}},
      '{siq_pkg::FUNC_SORTED,     -32'sd1,       1'b0, '0},
      '{siq_pkg::FUNC_SORTED,     32'sd0,        1'b0, '0},
      '{siq_pkg::FUNC_SORTED,     32'sd1,        1'b0, '0},
      '{siq_pkg::FUNC_SORTED,     -32'sd1,       1'b0, '0},
      '{siq_pkg::FUNC_PUSH_FRONT, 32'sd5,        1'b0, '0},
      '{siq_pkg::FUNC_SORTED,     32'sd3,        1'b0, '0},
      '{siq_pkg::FUNC_POP_FRONT,  32'shffffffff, 1'b0, '0},
      '{siq_pkg::FUNC_PUSH_REAR,  32'sd7,        1'b0, '0},
      '{siq_pkg::FUNC_PUSH_REAR,  -32'sd7,       1'b0, '0},
      '{siq_pkg::FUNC_PUSH_REAR,  32'sd1000,     1'b0, '0},
      '{siq_pkg::FUNC_PUSH_REAR,  -32'sd1000,    1'b0, '0},
      '{siq_pkg::FUNC_PUSH_REAR,  32'sd42,       1'b0, '0},
      '{siq_pkg::FUNC_PUSH_REAR,  32'sh7fffffff, 1'b0, '0},
      '{siq_pkg::FUNC_PUSH_REAR,  32'sh80000000, 1'b0, '0},
      '{siq_pkg::FUNC_PUSH_REAR,  32'sd2,        1'b0, '0},
      '{siq_pkg::FUNC_PUSH_REAR,  -32'sd2,       1'b0, '0},
      '{siq_pkg::FUNC_PUSH_REAR,  32'sd0,        1'b0, '0},
      '{siq_pkg::FUNC_PUSH_FRONT, 32'sh55555555, 1'b1,
        '{32'sd0, 1'b0, siq_pkg::STATUS_FULL, 5'd16, 1'b0}},
      '{siq_pkg::FUNC_SORTED,     32'shaaaaaaaa, 1'b1,
        '{32'sd0, 1'b0, siq_pkg::STATUS_FULL, 5'd16, 1'b0}},
      '{siq_pkg::FUNC_PUSH_REAR,  32'sd0,        1'b1,
        '{32'sd0, 1'b0, siq_pkg::STATUS_FULL, 5'd16, 1'b0}}
   };

   logic phase_order [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic rsp_beat_type apply_queue_op(
         input siq_pkg::func_type func,
         input logic signed [siq_pkg::DATA_W-1:0] value);
      rsp_beat_type beat;
      int           pos;
      logic         goes_before;
      beat = '0;
      beat.status = siq_pkg::STATUS_OK;
      if (func == siq_pkg::FUNC_POP_FRONT) begin
         if (held_values.size() == 0) begin
            beat.status = siq_pkg::STATUS_EMPTY;
         end else begin
            beat.popped_value = held_values.pop_front();
            beat.pop_valid = 1'b1;
         end
      end else if (held_values.size() >= QUEUE_DEPTH) begin
         beat.status = siq_pkg::STATUS_FULL;
      end else begin
         case (func)
            siq_pkg::FUNC_PUSH_FRONT: begin
               held_values.push_front(value);
            end
            siq_pkg::FUNC_PUSH_REAR: begin
               held_values.push_back(value);
            end
            default: begin
               pos = 0;
               while (pos < held_values.size()) begin
                  goes_before = descending_order ? (held_values[pos] < value)
                                                 : (held_values[pos] > value);
                  if (goes_before) break;
                  pos++;
               end
               held_values.insert(pos, value);
            end
         endcase
      end
      beat.length = siq_pkg::LENGTH_W'(held_values.size());
      beat.is_empty = (held_values.size() == 0);
      return beat;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [siq_pkg::DATA_W-1:0] got,
                                  input logic [siq_pkg::DATA_W-1:0] want);
      fail_count++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   task automatic send_item(input siq_pkg::func_type func,
                            input logic signed [siq_pkg::DATA_W-1:0] value,
                            input bit fixed, input rsp_beat_type want);
      while (!steady && $urandom_range(99) < 16) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      table_rsp.push_back('{fixed, want});
      req_if.valid <= 1'b1;
      req_if.func  <= func;
      req_if.value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0 || table_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [siq_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [siq_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == siq_pkg::CSR_SORT_DESCENDING) descending_order = data[0];
   endtask

   // response beats are checked before the request beat of the same edge is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got_beat = '{rsp_if.popped_value, rsp_if.pop_valid,
                         siq_pkg::status_type'(rsp_if.status),
                         rsp_if.length, rsp_if.is_empty};
            if (pending_rsp.size() == 0) begin
               report_mismatch("response beat with nothing pending", got_beat.popped_value, 0);
            end else begin
               want_beat = pending_rsp.pop_front();
               if (got_beat.popped_value !== want_beat.popped_value)
                  report_mismatch("popped_value", got_beat.popped_value, want_beat.popped_value);
               if (got_beat.pop_valid !== want_beat.pop_valid)
                  report_mismatch("pop_valid", got_beat.pop_valid, want_beat.pop_valid);
               if (got_beat.status !== want_beat.status)
                  report_mismatch("status", got_beat.status, want_beat.status);
               if (got_beat.length !== want_beat.length)
                  report_mismatch("length", got_beat.length, want_beat.length);
               if (got_beat.is_empty !== want_beat.is_empty)
                  report_mismatch("is_empty", got_beat.is_empty, want_beat.is_empty);
            end
         end
         if (req_if.valid && req_if.ready) begin
            want_beat = apply_queue_op(siq_pkg::func_type'(req_if.func), req_if.value);
            if (table_rsp.size() != 0) begin
               row_info = table_rsp.pop_front();
               if (row_info.fixed) want_beat = row_info.want;
            end
            beats_in++;
            if (want_beat.pop_valid) pops_done++;
            if (want_beat.status == siq_pkg::STATUS_FULL) full_drops++;
            if (want_beat.status == siq_pkg::STATUS_EMPTY) empty_pops++;
            pending_rsp.push_back(want_beat);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // receiver, with one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_if.ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_if.ready <= steady || ($urandom_range(99) >= 16);
      end
   end

   initial begin
      logic signed [siq_pkg::DATA_W-1:0] value;
      siq_pkg::func_type                 func;
      int unsigned                       pop_pct;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.func  <= siq_pkg::FUNC_PUSH_FRONT;
      req_if.value <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      pop_pct = 50;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      csr_write(siq_pkg::CSR_SORT_DESCENDING, 0);

      foreach (directed_rows[i])
         send_item(directed_rows[i].func, directed_rows[i].value,
                   directed_rows[i].fixed, directed_rows[i].want);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         csr_write(siq_pkg::CSR_SORT_DESCENDING,
                   siq_pkg::CSR_DATA_W'(phase_order[phase]));
         steady = (phase == 1);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // swing between filling and draining so both full and empty are reached
            if (n % 32 == 0) begin
               case ($urandom_range(2))
                  0: pop_pct = 15;
                  1: pop_pct = 50;
                  default: pop_pct = 85;
               endcase
            end
            if (phase == 2 && n == 40) hold_request = 1'b1;
            if (phase == 3 && n == 100) wait_drained();
            case ($urandom_range(9))
               0: value = 32'sh7fffffff;
               1: value = 32'sh80000000;
               2, 3, 4: value = siq_pkg::DATA_W'($urandom_range(8)) - 32'sd4;
               default: value = $urandom;
            endcase
            if ($urandom_range(99) < pop_pct) func = siq_pkg::FUNC_POP_FRONT;
            else func = siq_pkg::func_type'($urandom_range(2));
            send_item(func, value, 1'b0, '0);
         end
         wait_drained();
      end
      steady = 1'b0;
      repeat (4) @(posedge clock);

      if (pending_rsp.size() != 0)
         report_mismatch("response beats never arrived", pending_rsp.size(), 0);
      $display("ran %0d queue operations over %0d sort order settings, both directions",
               beats_in, PHASES + 1);
      $display("saw %0d pops, %0d pushes dropped on full, %0d pops on empty",
               pops_done, full_drops, empty_pops);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
